// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, reset by rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nsr_pkg.sv -----
// ---------------------------------------------------------------------------
// nsr_pkg
// shared constants and types of the newton square root block
// ---------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    // numerator of the divide: positive operand shifted up by the fraction bits
    localparam int NUM_W  = DATA_WIDTH - 1 + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int STEP_W = 6;
    localparam int TOL_W  = 16;
    localparam int ROOT_W = 24;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd7;
    localparam logic [STEP_W-1:0] LIMIT_RESET = 6'd32;

    // register index, taken from the word address bit
    localparam logic REG_IDX_TOLERANCE  = 1'b0;
    localparam logic REG_IDX_ITER_LIMIT = 1'b1;

    typedef struct packed {
        logic [TOL_W-1:0]  tolerance;
        logic [STEP_W-1:0] iteration_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/nsr_apb_regs.sv -----
// ---------------------------------------------------------------------------
// nsr_apb_regs
// apb register file holding tolerance and iteration limit
// ---------------------------------------------------------------------------
`default_nettype none

module nsr_apb_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nsr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [nsr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [nsr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output nsr_pkg::cfg_t                        cfg
);

    logic [nsr_pkg::TOL_W-1:0]  tolerance_reg;
    logic [nsr_pkg::STEP_W-1:0] limit_reg;
    logic                       reg_idx;

    assign reg_idx = paddr[nsr_pkg::APB_ADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= nsr_pkg::TOL_RESET;
            limit_reg     <= nsr_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                nsr_pkg::REG_IDX_TOLERANCE:
                begin
                    tolerance_reg <= pwdata[nsr_pkg::TOL_W-1:0];
                end
                nsr_pkg::REG_IDX_ITER_LIMIT:
                begin
                    limit_reg <= pwdata[nsr_pkg::STEP_W-1:0];
                end
                default:
                begin
                    tolerance_reg <= tolerance_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            nsr_pkg::REG_IDX_TOLERANCE:
            begin
                prdata = nsr_pkg::APB_DATA_W'(tolerance_reg);
            end
            nsr_pkg::REG_IDX_ITER_LIMIT:
            begin
                prdata = nsr_pkg::APB_DATA_W'(limit_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.tolerance       = tolerance_reg;
    assign cfg.iteration_limit = limit_reg;

endmodule

`default_nettype wire

// ----- hdl/nsr_divider.sv -----
// ---------------------------------------------------------------------------
// nsr_divider
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module nsr_divider
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [nsr_pkg::NUM_W-1:0]   num,
    input  wire logic [nsr_pkg::NUM_W-1:0]   den,
    output logic                             done,
    output logic      [nsr_pkg::NUM_W-1:0]   quot
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [nsr_pkg::CNT_W-1:0]     cnt_reg;
    logic [nsr_pkg::NUM_W:0]       rem_reg;
    logic [nsr_pkg::NUM_W-1:0]     den_reg;
    // numerator bits shift out at the top while quotient bits shift in
    logic [nsr_pkg::NUM_W-1:0]     quot_reg;

    logic [nsr_pkg::NUM_W:0]       rem_shift;
    logic [nsr_pkg::NUM_W:0]       rem_diff;
    logic                          fits;
    logic [nsr_pkg::NUM_W:0]       rem_next;
    logic [nsr_pkg::NUM_W-1:0]     quot_next;

    always_comb
    begin
        rem_shift = {rem_reg[nsr_pkg::NUM_W-1:0], quot_reg[nsr_pkg::NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
        rem_next  = fits ? rem_diff : rem_shift;
        quot_next = {quot_reg[nsr_pkg::NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            // pulse after the last quotient bit
            done_reg <= !start && busy_reg &&
                        (cnt_reg == nsr_pkg::CNT_W'(nsr_pkg::NUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= den;
                quot_reg <= num;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == nsr_pkg::CNT_W'(nsr_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- hdl/newton_square_root.sv -----
// ---------------------------------------------------------------------------
// newton_square_root
// fixed-point square root by newton iteration over a shared divider
// ---------------------------------------------------------------------------
// Takes a signed Q16.16 operand and returns its root in unsigned Q8.16
// (24 bits, saturating at all ones). The estimate starts at the operand and
// each newton step replaces it by (x + (A << 16) / x) >> 1 until two successive
// estimates differ by less than the tolerance register; reaching the
// iteration limit first sets not_converged. A negative operand gives root zero
// with negative_input set, a zero operand gives zero at once. Every step runs
// through one restoring divider that produces one quotient bit per cycle over
// a 47-bit numerator; a step is a check of the estimate, the divide, and the
// update of the estimate once the divider is done. Negative and zero operands
// go straight to the finish state. The input side stalls from acceptance until
// the result is handed to the output register; a finished result may wait
// there while the next transaction is accepted. Configuration goes through the
// apb port: tolerance at address 0, iteration limit at address 4.
// ---------------------------------------------------------------------------
`default_nettype none

module newton_square_root
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input transaction
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [nsr_pkg::DATA_WIDTH-1:0] operand_value,
    // output transaction
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [nsr_pkg::ROOT_W-1:0]        root,
    output logic                                   negative_input,
    output logic                                   not_converged,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nsr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [nsr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [nsr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    nsr_pkg::cfg_t cfg;

    state_t                          state_reg;
    logic [nsr_pkg::DATA_WIDTH-2:0]  raw_reg;     // positive operand magnitude
    logic [nsr_pkg::NUM_W-1:0]       x_reg;       // current estimate
    logic [nsr_pkg::NUM_W-1:0]       prev_reg;    // previous estimate
    logic [nsr_pkg::STEP_W-1:0]      steps_reg;
    logic                            neg_reg;
    logic                            nc_reg;

    logic                            out_valid_reg;
    logic [nsr_pkg::ROOT_W-1:0]      root_reg;
    logic                            neg_out_reg;
    logic                            nc_out_reg;

    logic [nsr_pkg::NUM_W-1:0]       diff;
    logic                            converged;
    logic                            at_limit;
    logic                            div_start;
    logic                            div_done;
    logic [nsr_pkg::NUM_W-1:0]       div_num;
    logic [nsr_pkg::NUM_W-1:0]       div_den;
    logic [nsr_pkg::NUM_W-1:0]       div_quot;
    logic [nsr_pkg::NUM_W:0]         sum;
    logic [nsr_pkg::ROOT_W-1:0]      root_sat;
    logic                            out_free;

    nsr_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // |x - prev| against the tolerance, then the step limit
    always_comb
    begin
        diff      = (x_reg >= prev_reg) ? (x_reg - prev_reg) : (prev_reg - x_reg);
        converged = (diff < nsr_pkg::NUM_W'(cfg.tolerance));
        at_limit  = (steps_reg >= cfg.iteration_limit);
    end

    // numerator is the operand scaled by the fraction bits
    assign div_num   = {raw_reg, {nsr_pkg::FRAC_BITS{1'b0}}};
    // a zero estimate cannot occur for a positive operand; guard the divide
    assign div_den   = (x_reg == '0) ? nsr_pkg::NUM_W'(1) : x_reg;
    assign div_start = (state_reg == ST_CHECK) && !converged && !at_limit;

    nsr_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // newton update: average of estimate and quotient, truncated
    assign sum = {1'b0, x_reg} + {1'b0, div_quot};

    // saturate the estimate to the root width
    assign root_sat = (64'(x_reg) > 64'({nsr_pkg::ROOT_W{1'b1}}))
                    ? {nsr_pkg::ROOT_W{1'b1}} : nsr_pkg::ROOT_W'(x_reg);

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            raw_reg       <= '0;
            x_reg         <= '0;
            prev_reg      <= '0;
            steps_reg     <= '0;
            neg_reg       <= 1'b0;
            nc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
            neg_out_reg   <= 1'b0;
            nc_out_reg    <= 1'b0;
        end
        else
        begin
            // output transaction taken, unless a new result replaces it
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        raw_reg   <= operand_value[nsr_pkg::DATA_WIDTH-2:0];
                        prev_reg  <= '0;
                        steps_reg <= '0;
                        nc_reg    <= 1'b0;
                        if (operand_value[nsr_pkg::DATA_WIDTH-1])
                        begin
                            // negative operand: flag and return zero
                            neg_reg   <= 1'b1;
                            x_reg     <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else if (operand_value == '0)
                        begin
                            neg_reg   <= 1'b0;
                            x_reg     <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            neg_reg   <= 1'b0;
                            x_reg     <= nsr_pkg::NUM_W'(operand_value[nsr_pkg::DATA_WIDTH-2:0]);
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK:
                begin
                    if (converged)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (at_limit)
                    begin
                        nc_reg    <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        // divider launched this cycle
                        prev_reg  <= x_reg;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        x_reg     <= sum[nsr_pkg::NUM_W:1];
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        root_reg      <= root_sat;
                        neg_out_reg   <= neg_reg;
                        nc_out_reg    <= nc_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign root           = root_reg;
    assign negative_input = neg_out_reg;
    assign not_converged  = nc_out_reg;

endmodule

`default_nettype wire

// ----- hdl/nsr_checker.sv -----
// ---------------------------------------------------------------------------
// nsr_checker
// port-level assertions for the newton square root block
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nsr_checker
(
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_stall,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic [nsr_pkg::ROOT_W-1:0]            root,
    input wire logic                                  negative_input,
    input wire logic                                  not_converged
);

    // stalled result transaction holds
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(root) && $stable(negative_input) && $stable(not_converged),
        "stalled result changed")

    // the block is busy right after taking a transaction
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input not stalled after accept")

    // negative operand gives zero root and no convergence flag
    `ASSERT_IMPLIES(a_neg_result, out_valid && negative_input,
        root == '0 && !not_converged, "bad result for negative operand")

    // a zero root only comes from a zero or negative operand, which never iterates
    `ASSERT_IMPLIES(a_zero_root, out_valid && root == '0, !not_converged,
        "zero root flagged as not converged")

endmodule

bind newton_square_root nsr_checker u_nsr_checker (.*);

`default_nettype wire
